>>> hdl/usc_pkg.sv
// Shared types and constants for the unslotted CSMA-CA backoff engine.
// No dependencies; every other file of the block refers to this package.
package usc_pkg;

    localparam int unsigned CmdW      = 3;
    localparam int unsigned RandW     = 8;
    localparam int unsigned ExpW      = 4;
    localparam int unsigned CountW    = 4;
    localparam int unsigned PeriodW   = 10;
    localparam int unsigned CountdownW = RandW + PeriodW;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = PeriodW;

    localparam logic [ExpW-1:0]    MinBeReset     = 4'd3;
    localparam logic [ExpW-1:0]    MaxBeReset     = 4'd5;
    localparam logic [CountW-1:0]  MaxBackoffsReset = 4'd4;
    localparam logic [PeriodW-1:0] UnitPeriodReset = 10'd320;
    localparam logic [CountW-1:0]  NbMax          = 4'hF;

    typedef enum logic [CmdW-1:0] {
        CMD_START   = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_DENIED  = 3'd2,
        CMD_BUSY    = 3'd3,
        CMD_STARTED = 3'd4,
        CMD_ABORT   = 3'd5
    } t_cmd;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MIN_BE      = 2'd0,
        CFG_MAX_BE      = 2'd1,
        CFG_MAX_BACKOFFS = 2'd2,
        CFG_UNIT_PERIOD = 2'd3
    } t_cfg_idx;

endpackage

>>> hdl/usc_evt_if.sv
// Event channel of the unslotted CSMA-CA backoff engine: one word per event.
// Depends on usc_pkg for field widths.
interface usc_evt_if;
    logic                       valid;
    logic                       ready;
    logic [usc_pkg::CmdW-1:0]   cmd;
    logic [usc_pkg::RandW-1:0]  random_value;

    modport source (output valid, output cmd, output random_value, input ready);
    modport sink   (input valid, input cmd, input random_value, output ready);
endinterface

>>> hdl/usc_res_if.sv
// Result channel of the unslotted CSMA-CA backoff engine: one word per event.
// Depends on usc_pkg for field widths.
interface usc_res_if;
    logic                        valid;
    logic                        ready;
    logic                        request_transmit;
    logic                        report_failure;
    logic                        running;
    logic [usc_pkg::CountW-1:0]  backoff_count;
    logic [usc_pkg::ExpW-1:0]    backoff_exponent;

    modport source (output valid, output request_transmit, output report_failure,
                    output running, output backoff_count, output backoff_exponent,
                    input ready);
    modport sink   (input valid, input request_transmit, input report_failure,
                    input running, input backoff_count, input backoff_exponent,
                    output ready);
endinterface

>>> hdl/unslotted_csma_ca_backoff.sv
// Unslotted CSMA-CA backoff engine: NB/BE tracking and backoff countdown.
// An event word goes through the input register, then the result register.
// Throughput: one event per cycle while results are taken; the input and
// result registers let a next word in while a result waits for the sink.
// Reset is synchronous and active low: procedure state clears and the
// configuration registers return to their default values.
module unslotted_csma_ca_backoff (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [usc_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [usc_pkg::CfgDataW-1:0]     i_cfg_data,
    usc_evt_if.sink                          i_evt,
    usc_res_if.source                        o_res
);

    logic [usc_pkg::ExpW-1:0]       r_min_be;
    logic [usc_pkg::ExpW-1:0]       r_max_be;
    logic [usc_pkg::CountW-1:0]     r_max_backoffs;
    logic [usc_pkg::PeriodW-1:0]    r_unit_period;

    logic                           r_in_valid;
    usc_pkg::t_cmd                  r_cmd;
    logic [usc_pkg::RandW-1:0]      r_rnd;

    logic [usc_pkg::CountW-1:0]     r_nb;
    logic [usc_pkg::ExpW-1:0]       r_be;
    logic                           r_active;
    logic                           r_waiting;
    logic [usc_pkg::CountdownW-1:0] r_countdown;

    logic                           r_out_valid;
    logic                           r_req;
    logic                           r_fail;

    logic [usc_pkg::CountW-1:0]     n_nb;
    logic [usc_pkg::ExpW-1:0]       n_be;
    logic                           n_active;
    logic                           n_waiting;
    logic [usc_pkg::CountdownW-1:0] n_countdown;
    logic                           n_req;
    logic                           n_fail;

    logic                           w_adv;
    logic                           w_fire;
    logic                           w_backoff;
    logic [usc_pkg::ExpW-1:0]       w_be_bo;
    logic [usc_pkg::RandW-1:0]      w_mask;
    logic [usc_pkg::RandW-1:0]      w_periods;
    logic [usc_pkg::CountdownW-1:0] w_backoff_len;
    logic [usc_pkg::CountW-1:0]     w_nb_inc;
    logic [usc_pkg::ExpW-1:0]       w_be_inc;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign w_fire      = r_in_valid && w_adv;
    assign i_evt.ready = !r_in_valid || w_adv;

    assign w_nb_inc = (r_nb == usc_pkg::NbMax) ? r_nb : r_nb + 4'd1;
    assign w_be_inc = (r_be < r_max_be) ? r_be + 4'd1 : r_be;
    assign w_be_bo  = (r_cmd == usc_pkg::CMD_START) ? r_min_be : w_be_inc;

    always_comb begin
        if (w_be_bo >= 4'd8) begin
            w_mask = 8'hFF;
        end else begin
            w_mask = 8'((9'd1 << w_be_bo[2:0]) - 9'd1);
        end
        w_periods     = r_rnd & w_mask;
        w_backoff_len = usc_pkg::CountdownW'(w_periods)
                      * usc_pkg::CountdownW'(r_unit_period);
    end

    always_comb begin
        n_nb        = r_nb;
        n_be        = r_be;
        n_active    = r_active;
        n_waiting   = r_waiting;
        n_countdown = r_countdown;
        n_req       = 1'b0;
        n_fail      = 1'b0;
        w_backoff   = 1'b0;
        unique case (r_cmd)
            usc_pkg::CMD_START: begin
                if (!r_active) begin
                    n_active  = 1'b1;
                    n_nb      = '0;
                    n_be      = r_min_be;
                    w_backoff = 1'b1;
                end
            end
            usc_pkg::CMD_TICK: begin
                if (r_waiting) begin
                    if (r_countdown <= 18'd1) begin
                        n_countdown = '0;
                        n_waiting   = 1'b0;
                        n_req       = 1'b1;
                    end else begin
                        n_countdown = r_countdown - 18'd1;
                    end
                end
            end
            usc_pkg::CMD_DENIED, usc_pkg::CMD_BUSY: begin
                if (!r_active) begin
                    n_fail = 1'b1;
                end else begin
                    n_nb = w_nb_inc;
                    n_be = w_be_inc;
                    if (w_nb_inc < r_max_backoffs) begin
                        w_backoff = 1'b1;
                    end else begin
                        n_active    = 1'b0;
                        n_waiting   = 1'b0;
                        n_countdown = '0;
                        n_fail      = 1'b1;
                    end
                end
            end
            usc_pkg::CMD_STARTED, usc_pkg::CMD_ABORT: begin
                n_active    = 1'b0;
                n_waiting   = 1'b0;
                n_countdown = '0;
            end
            default: begin
            end
        endcase
        if (w_backoff) begin
            n_countdown = w_backoff_len;
            n_waiting   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_be       <= usc_pkg::MinBeReset;
            r_max_be       <= usc_pkg::MaxBeReset;
            r_max_backoffs <= usc_pkg::MaxBackoffsReset;
            r_unit_period  <= usc_pkg::UnitPeriodReset;
        end else if (i_cfg_we) begin
            unique case (usc_pkg::t_cfg_idx'(i_cfg_idx))
                usc_pkg::CFG_MIN_BE:       r_min_be       <= i_cfg_data[3:0];
                usc_pkg::CFG_MAX_BE:       r_max_be       <= i_cfg_data[3:0];
                usc_pkg::CFG_MAX_BACKOFFS: r_max_backoffs <= i_cfg_data[3:0];
                usc_pkg::CFG_UNIT_PERIOD:  r_unit_period  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.valid && i_evt.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_cmd <= usc_pkg::t_cmd'(i_evt.cmd);
            r_rnd <= i_evt.random_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb        <= '0;
            r_be        <= '0;
            r_active    <= 1'b0;
            r_waiting   <= 1'b0;
            r_countdown <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_nb        <= n_nb;
                r_be        <= n_be;
                r_active    <= n_active;
                r_waiting   <= n_waiting;
                r_countdown <= n_countdown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_req  <= n_req;
            r_fail <= n_fail;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.request_transmit = r_req;
    assign o_res.report_failure   = r_fail;
    assign o_res.running          = r_active;
    assign o_res.backoff_count    = r_nb;
    assign o_res.backoff_exponent = r_be;

`ifndef SYNTHESIS
    a_wait_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting |-> r_active)
        else $error("Backoff countdown in progress without a running procedure.");

    a_countdown_needs_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_countdown != '0) |-> r_waiting)
        else $error("Countdown left nonzero outside a backoff.");

    a_req_fail_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_req && r_fail))
        else $error("Transmit request and failure reported for one event.");

    a_fail_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fail) |-> !r_active)
        else $error("Failure reported while the procedure still runs.");
`endif

endmodule

>>> verif/tb_unslotted_csma_ca_backoff.sv
`timescale 1ns / 100ps
// Self-checking testbench for the unslotted CSMA-CA backoff engine.
// Drives event words through usc_evt_if, predicts NB, BE and the backoff countdown in
// step with accepted words, and checks every result word from usc_res_if (uses usc_pkg).
module tb_unslotted_csma_ca_backoff;

    localparam logic [usc_pkg::CmdW-1:0] CmdSpare6 = 3'd6;
    localparam logic [usc_pkg::CmdW-1:0] CmdSpare7 = 3'd7;
    localparam int unsigned PhaseWords = 170;
    localparam int unsigned TickCap = 40;
    localparam int unsigned SettleCycles = 4;

    typedef struct packed {
        logic [usc_pkg::CmdW-1:0]  cmd;
        logic [usc_pkg::RandW-1:0] rnd;
    } t_event_word;

    typedef struct packed {
        logic                       request_transmit;
        logic                       report_failure;
        logic                       running;
        logic [usc_pkg::CountW-1:0] backoff_count;
        logic [usc_pkg::ExpW-1:0]   backoff_exponent;
    } t_backoff_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_QUARTER,
        RX_LONG
    } t_rx_mode;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [usc_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [usc_pkg::CfgDataW-1:0] i_cfg_data;

    usc_evt_if evt_ch ();
    usc_res_if res_ch ();

    unslotted_csma_ca_backoff u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (evt_ch),
        .o_res      (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Configuration as the engine should hold it.
    logic [usc_pkg::ExpW-1:0]    cfg_min_be       = usc_pkg::MinBeReset;
    logic [usc_pkg::ExpW-1:0]    cfg_max_be       = usc_pkg::MaxBeReset;
    logic [usc_pkg::CountW-1:0]  cfg_max_backoffs = usc_pkg::MaxBackoffsReset;
    logic [usc_pkg::PeriodW-1:0] cfg_unit         = usc_pkg::UnitPeriodReset;

    // Procedure state as the engine should hold it.
    logic [usc_pkg::CountW-1:0]     bo_nb        = '0;
    logic [usc_pkg::ExpW-1:0]       bo_be        = '0;
    logic                           bo_active    = 1'b0;
    logic                           bo_waiting   = 1'b0;
    logic [usc_pkg::CountdownW-1:0] bo_countdown = '0;

    t_event_word     pending_words[$];
    t_backoff_result backoff_results[$];
    int unsigned     phase_words;
    int unsigned     mismatch_count = 0;
    int unsigned     gap_left;
    int unsigned     burst_left;
    t_rx_mode        rx_mode;
    logic [5:0]      rx_cycle;

    function automatic void load_countdown(logic [usc_pkg::RandW-1:0] rnd);
        logic [usc_pkg::RandW-1:0] periods;
        periods = rnd;
        if (bo_be < usc_pkg::RandW) begin
            periods = rnd & usc_pkg::RandW'((9'd1 << bo_be) - 9'd1);
        end
        bo_countdown = usc_pkg::CountdownW'(periods) * usc_pkg::CountdownW'(cfg_unit);
        bo_waiting = 1'b1;
    endfunction

    function automatic void halt_backoff();
        bo_active = 1'b0;
        bo_waiting = 1'b0;
        bo_countdown = '0;
    endfunction

    function automatic t_backoff_result apply_event(logic [usc_pkg::CmdW-1:0] cmd,
                                                    logic [usc_pkg::RandW-1:0] rnd);
        t_backoff_result r;
        r = '0;
        case (cmd)
            usc_pkg::CMD_START: begin
                if (!bo_active) begin
                    bo_active = 1'b1;
                    bo_nb = '0;
                    bo_be = cfg_min_be;
                    load_countdown(rnd);
                end
            end
            usc_pkg::CMD_TICK: begin
                if (bo_waiting) begin
                    if (bo_countdown <= 1) begin
                        bo_countdown = '0;
                        bo_waiting = 1'b0;
                        r.request_transmit = 1'b1;
                    end else begin
                        bo_countdown = bo_countdown - 1'b1;
                    end
                end
            end
            usc_pkg::CMD_DENIED, usc_pkg::CMD_BUSY: begin
                if (!bo_active) begin
                    r.report_failure = 1'b1;
                end else begin
                    if (bo_nb != usc_pkg::NbMax) begin
                        bo_nb = bo_nb + 1'b1;
                    end
                    if (bo_be < cfg_max_be) begin
                        bo_be = bo_be + 1'b1;
                    end
                    if (bo_nb < cfg_max_backoffs) begin
                        load_countdown(rnd);
                    end else begin
                        halt_backoff();
                        r.report_failure = 1'b1;
                    end
                end
            end
            usc_pkg::CMD_STARTED, usc_pkg::CMD_ABORT: begin
                halt_backoff();
            end
            default: begin
            end
        endcase
        r.running = bo_active;
        r.backoff_count = bo_nb;
        r.backoff_exponent = bo_be;
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        t_event_word next_word;
        if (!i_rst_n) begin
            evt_ch.valid <= 1'b0;
            evt_ch.cmd <= usc_pkg::CMD_START;
            evt_ch.random_value <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            if (evt_ch.valid && evt_ch.ready) begin
                backoff_results.push_back(apply_event(evt_ch.cmd, evt_ch.random_value));
            end
            if (!evt_ch.valid || evt_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    evt_ch.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    next_word = pending_words.pop_front();
                    evt_ch.valid <= 1'b1;
                    evt_ch.cmd <= next_word.cmd;
                    evt_ch.random_value <= next_word.rnd;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(24, 1);
                        gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    evt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the stall pattern is drawn anew whenever the 6-bit cycle counter wraps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rx_mode <= RX_ALWAYS;
            rx_cycle <= '0;
        end else begin
            rx_cycle <= rx_cycle + 1'b1;
            if (rx_cycle == '0) begin
                rx_mode <= t_rx_mode'($urandom_range(3));
            end
            case (rx_mode)
                RX_ALWAYS:  res_ch.ready <= 1'b1;
                RX_COIN:    res_ch.ready <= 1'($urandom_range(1));
                RX_QUARTER: res_ch.ready <= (rx_cycle[1:0] != 2'd0);
                default:    res_ch.ready <= ($urandom_range(7) == 0) ? !res_ch.ready
                                                                     : res_ch.ready;
            endcase
        end
    end

    task automatic check_field(string fname, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_backoff_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (backoff_results.size() == 0) begin
                $display("%0t: result word with no prediction pending", $time);
                mismatch_count++;
            end else begin
                want = backoff_results.pop_front();
                check_field("request_transmit", want.request_transmit,
                            res_ch.request_transmit);
                check_field("report_failure", want.report_failure, res_ch.report_failure);
                check_field("running", want.running, res_ch.running);
                check_field("backoff_count", want.backoff_count, res_ch.backoff_count);
                check_field("backoff_exponent", want.backoff_exponent,
                            res_ch.backoff_exponent);
            end
        end
    end

    task automatic add_word(logic [usc_pkg::CmdW-1:0] cmd, logic [usc_pkg::RandW-1:0] rnd);
        pending_words.push_back('{cmd: cmd, rnd: rnd});
        phase_words++;
    endtask

    task automatic write_reg(usc_pkg::t_cfg_idx idx, logic [usc_pkg::CfgDataW-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            usc_pkg::CFG_MIN_BE:       cfg_min_be = usc_pkg::ExpW'(value);
            usc_pkg::CFG_MAX_BE:       cfg_max_be = usc_pkg::ExpW'(value);
            usc_pkg::CFG_MAX_BACKOFFS: cfg_max_backoffs = usc_pkg::CountW'(value);
            default:                   cfg_unit = usc_pkg::PeriodW'(value);
        endcase
    endtask

    task automatic apply_settings(int unsigned min_be, int unsigned max_be,
                                  int unsigned max_nb, int unsigned unit);
        write_reg(usc_pkg::CFG_MIN_BE, usc_pkg::CfgDataW'(min_be));
        write_reg(usc_pkg::CFG_MAX_BE, usc_pkg::CfgDataW'(max_be));
        write_reg(usc_pkg::CFG_MAX_BACKOFFS, usc_pkg::CfgDataW'(max_nb));
        write_reg(usc_pkg::CFG_UNIT_PERIOD, usc_pkg::CfgDataW'(unit));
        phase_words = 0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || evt_ch.valid || backoff_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic [usc_pkg::RandW-1:0] pick_backoff_rnd();
        return ($urandom_range(3) == 0) ? usc_pkg::RandW'($urandom_range(255))
                                        : usc_pkg::RandW'($urandom_range(7));
    endfunction

    // One procedure: start, then backoffs that mostly run out, each ended by a
    // busy channel or a denial, a transmit start or an abort.
    task automatic queue_procedure();
        logic [usc_pkg::RandW-1:0] backoff_rnd;
        int unsigned full_ticks;
        int unsigned ticks;
        int unsigned outcome;
        backoff_rnd = pick_backoff_rnd();
        add_word(usc_pkg::CMD_START, backoff_rnd);
        for (int unsigned attempt = 0; attempt <= cfg_max_backoffs; attempt++) begin
            full_ticks = int'(backoff_rnd) * int'(cfg_unit) + 1;
            if (full_ticks > TickCap) begin
                full_ticks = TickCap;
            end
            ticks = ($urandom_range(3) == 0) ? $urandom_range(full_ticks) : full_ticks;
            repeat (ticks) add_word(usc_pkg::CMD_TICK, usc_pkg::RandW'($urandom_range(255)));
            outcome = $urandom_range(19);
            if (outcome < 3) begin
                add_word(usc_pkg::CMD_STARTED, usc_pkg::RandW'($urandom_range(255)));
                return;
            end else if (outcome < 5) begin
                add_word(usc_pkg::CMD_ABORT, usc_pkg::RandW'($urandom_range(255)));
                return;
            end else if (outcome == 5) begin
                add_word(usc_pkg::CMD_START, usc_pkg::RandW'($urandom_range(255)));
            end
            backoff_rnd = pick_backoff_rnd();
            add_word(($urandom_range(1) == 0) ? usc_pkg::CMD_BUSY : usc_pkg::CMD_DENIED,
                     backoff_rnd);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = usc_pkg::CFG_MIN_BE;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default settings: busy while idle, start while running, expiry on a zero
        // countdown, unused codes and the stop commands.
        add_word(usc_pkg::CMD_BUSY, 8'hFF);
        add_word(usc_pkg::CMD_DENIED, 8'h00);
        add_word(usc_pkg::CMD_TICK, 8'h00);
        add_word(usc_pkg::CMD_START, 8'h00);
        add_word(usc_pkg::CMD_START, 8'hFF);
        add_word(usc_pkg::CMD_TICK, 8'h00);
        add_word(usc_pkg::CMD_TICK, 8'h00);
        add_word(usc_pkg::CMD_BUSY, 8'h01);
        add_word(CmdSpare6, 8'hAA);
        add_word(CmdSpare7, 8'h55);
        add_word(usc_pkg::CMD_ABORT, 8'h00);
        add_word(usc_pkg::CMD_START, 8'h08);
        add_word(usc_pkg::CMD_TICK, 8'h00);
        add_word(usc_pkg::CMD_STARTED, 8'h00);
        drain();

        // Minimum exponent above the maximum, longest countdown, no retries allowed.
        apply_settings(8, 0, 0, 1023);
        add_word(usc_pkg::CMD_START, 8'hFF);
        add_word(usc_pkg::CMD_TICK, 8'h00);
        add_word(usc_pkg::CMD_DENIED, 8'h00);
        drain();

        // A zero unit period makes every backoff expire on the next tick.
        apply_settings(0, 8, 2, 0);
        add_word(usc_pkg::CMD_START, 8'hFF);
        add_word(usc_pkg::CMD_TICK, 8'h00);
        add_word(usc_pkg::CMD_BUSY, 8'hFF);
        add_word(usc_pkg::CMD_TICK, 8'h00);
        add_word(usc_pkg::CMD_BUSY, 8'h00);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: apply_settings(0, 0, 0, 1);
                1: apply_settings(8, 8, 15, 1023);
                2: apply_settings(0, 8, 15, 1);
                default: apply_settings($urandom_range(8), $urandom_range(8),
                                        $urandom_range(15),
                                        ($urandom_range(4) == 0) ? $urandom_range(1023, 1)
                                                                 : $urandom_range(4, 1));
            endcase
            while (phase_words < PhaseWords) begin
                if ($urandom_range(7) == 0) begin
                    add_word(usc_pkg::CmdW'($urandom_range(7)),
                             usc_pkg::RandW'($urandom_range(255)));
                end else begin
                    queue_procedure();
                end
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> unslotted_csma_ca_backoff.f
hdl/usc_pkg.sv
hdl/usc_evt_if.sv
hdl/usc_res_if.sv
hdl/unslotted_csma_ca_backoff.sv
verif/tb_unslotted_csma_ca_backoff.sv
